// ===== rtl/core/wmpl_pkg.sv =====
// Package for the warp marker piecewise linear map core.
// Holds widths, command codes and register indexes; no dependencies.
package wmpl_pkg;
    localparam int MAX_MARKERS = 64;
    localparam int FRAME_BITS  = 24;
    localparam int FIELD_BITS  = FRAME_BITS + 1;
    localparam int IDX_BITS    = $clog2(MAX_MARKERS);
    localparam int CNT_BITS    = $clog2(MAX_MARKERS + 1);
    localparam int PROD_BITS   = 2 * FRAME_BITS + 2;

    localparam logic [1:0] CMD_CLEAR  = 2'd0;
    localparam logic [1:0] CMD_INSERT = 2'd1;
    localparam logic [1:0] CMD_QUERY  = 2'd2;
    localparam logic [1:0] CMD_NONE   = 2'd3;

    localparam logic CFG_SRC_LIMIT  = 1'b0;
    localparam logic CFG_PROJ_COUNT = 1'b1;

    typedef logic [FRAME_BITS-1:0]        frame_t;
    typedef logic signed [FIELD_BITS-1:0] field_t;
endpackage

// ===== rtl/core/wmpl_if.sv =====
// Channel interfaces for the warp marker map core.
// Depends on wmpl_pkg for field widths.
interface wmpl_in_if import wmpl_pkg::*; ();
    logic       valid;
    logic       ready;
    logic [1:0] command;
    field_t     marker_source;
    field_t     marker_output;
    field_t     query_source;
    modport source (output valid, command, marker_source, marker_output, query_source,
                    input ready);
    modport sink (input valid, command, marker_source, marker_output, query_source,
                  output ready);
endinterface

interface wmpl_out_if import wmpl_pkg::*; ();
    logic   valid;
    logic   ready;
    frame_t mapped_frame;
    logic   status;
    modport source (output valid, mapped_frame, status, input ready);
    modport sink (input valid, mapped_frame, status, output ready);
endinterface

interface wmpl_cfg_if import wmpl_pkg::*; ();
    logic       valid;
    logic       ready;
    logic [0:0] index;
    frame_t     data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/core/warp_marker_piecewise_linear_map_core.sv =====
// Warp marker piecewise linear map core: top level and sequencer.
// Depends on wmpl_pkg and the channel interfaces in wmpl_if.sv.
//
// Usage: items arrive on in_ch (command, marker, query), one result item per
// input item leaves on out_ch. The user must write registers on cfg_ch (index 0
// source frame limit, index 1 project frame count) only while the core is idle;
// the core does not enforce this. The marker table is a 64-entry memory (source
// and output words) with one registered read port; the sequencer steps it one
// entry at a time, reading an entry in one state and checking it in the next.
// Clear zeroes the marker count. Insert scans for the place, then shifts the tail up.
// Query: one pass for the output limit, one pass over the markers, then a
// restoring divider. One item is in the core at a time; in_ch.ready is low
// from acceptance until the result register is free again.
// The result sits in an output register; a stalled receiver holds it and the
// core accepts no item until it is taken.
// Reset clears the marker count and both registers; table contents are left
// undefined and entries beyond the count are never read.
module warp_marker_piecewise_linear_map_core
    import wmpl_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    wmpl_in_if.sink     in_ch,
    wmpl_out_if.source  out_ch,
    wmpl_cfg_if.sink    cfg_ch
);
    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_IRD   = 4'd1;
    localparam logic [3:0] ST_ICHK  = 4'd2;
    localparam logic [3:0] ST_SRD   = 4'd3;
    localparam logic [3:0] ST_SWR   = 4'd4;
    localparam logic [3:0] ST_LRD   = 4'd5;
    localparam logic [3:0] ST_LCHK  = 4'd6;
    localparam logic [3:0] ST_WRD   = 4'd7;
    localparam logic [3:0] ST_WCHK  = 4'd8;
    localparam logic [3:0] ST_MUL   = 4'd9;
    localparam logic [3:0] ST_DIV   = 4'd10;
    localparam logic [3:0] ST_DONE  = 4'd11;
    localparam logic [3:0] ST_OUT   = 4'd12;
    localparam int DIV_STEPS = PROD_BITS;
    localparam int DCNT_BITS = $clog2(DIV_STEPS + 1);
    localparam int SW        = FIELD_BITS + 1;

    typedef logic signed [SW-1:0] wide_t;

    // marker memory
    field_t mem_src [MAX_MARKERS];
    field_t mem_out [MAX_MARKERS];
    field_t rd_src_reg, rd_out_reg;
    logic [IDX_BITS-1:0] rd_addr, wr_addr;
    logic   wr_en;
    field_t wr_src, wr_out;

    logic [3:0]          state_reg, state_next;
    logic [CNT_BITS-1:0] count_reg, count_next;
    logic [CNT_BITS-1:0] idx_reg, idx_next;
    frame_t              lim_reg, proj_reg;
    field_t              ms_reg, mo_reg;
    wide_t               q_reg, q_next;
    wide_t               oe_reg, oe_next, ps_reg, ps_next, po_reg, po_next;
    wide_t               s_reg, s_next, o_reg, o_next;
    field_t              hold_src_reg, hold_src_next, hold_out_reg, hold_out_next;
    logic [PROD_BITS-1:0] num_reg, num_next;   // 2*dq*dout+span, then quotient
    logic [PROD_BITS-1:0] den_reg, den_next;   // 2*span
    logic [PROD_BITS:0]   rem_reg, rem_next;
    logic [DCNT_BITS-1:0] dcnt_reg, dcnt_next;
    frame_t               res_reg, res_next;
    logic                 stat_reg, stat_next;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_src[wr_addr] <= wr_src;
            mem_out[wr_addr] <= wr_out;
        end
        rd_src_reg <= mem_src[rd_addr];
        rd_out_reg <= mem_out[rd_addr];
    end

    // configuration registers
    assign cfg_ch.ready = 1'b1;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lim_reg  <= '0;
            proj_reg <= '0;
        end
        else if (cfg_ch.valid)
        begin
            unique case (cfg_ch.index[0])
                CFG_SRC_LIMIT:  lim_reg  <= cfg_ch.data;
                CFG_PROJ_COUNT: proj_reg <= cfg_ch.data;
                default: ;
            endcase
        end
    end

    assign in_ch.ready         = (state_reg == ST_IDLE);
    assign out_ch.valid        = (state_reg == ST_OUT);
    assign out_ch.mapped_frame = res_reg;
    assign out_ch.status       = stat_reg;

    wide_t lim_w, clo, mul_a, mul_b, span_w;
    logic [PROD_BITS-1:0] prod;
    logic [PROD_BITS:0]   trial;
    assign lim_w = wide_t'({1'b0, lim_reg});
    assign mul_a = q_reg - ps_reg;
    assign mul_b = (o_reg > po_reg) ? (o_reg - po_reg) : '0;
    assign span_w = (s_reg - ps_reg > 1) ? (s_reg - ps_reg) : wide_t'(1);
    assign prod  = PROD_BITS'(mul_a[FIELD_BITS-1:0]) * PROD_BITS'(mul_b[FIELD_BITS-1:0]);
    assign trial = {rem_reg[PROD_BITS-1:0], num_reg[PROD_BITS-1]};

    always_comb
    begin
        state_next = state_reg;  count_next = count_reg;  idx_next = idx_reg;
        q_next = q_reg;  oe_next = oe_reg;  ps_next = ps_reg;  po_next = po_reg;
        s_next = s_reg;  o_next = o_reg;
        hold_src_next = hold_src_reg;  hold_out_next = hold_out_reg;
        num_next = num_reg;  den_next = den_reg;  rem_next = rem_reg;
        dcnt_next = dcnt_reg;  res_next = res_reg;  stat_next = stat_reg;
        rd_addr = idx_reg[IDX_BITS-1:0];
        wr_en = 1'b0;  wr_addr = idx_reg[IDX_BITS-1:0];
        wr_src = ms_reg;  wr_out = mo_reg;
        clo = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                idx_next = '0;
                res_next = '0;  stat_next = 1'b0;
                if (in_ch.valid)
                begin
                    unique case (in_ch.command)
                        CMD_CLEAR:
                        begin
                            count_next = '0;
                            state_next = ST_OUT;
                        end
                        CMD_INSERT: state_next = ST_IRD;
                        CMD_QUERY:
                        begin
                            if (in_ch.query_source < 0)
                                q_next = '0;
                            else if (wide_t'(in_ch.query_source) > wide_t'({1'b0, lim_reg}))
                                q_next = wide_t'({1'b0, lim_reg});
                            else
                                q_next = wide_t'(in_ch.query_source);
                            oe_next = '0;
                            state_next = ST_LRD;
                        end
                        default: state_next = ST_OUT;
                    endcase
                end
            end
            // insert: find first entry with source >= new source
            ST_IRD:
            begin
                if (idx_reg == count_reg)
                begin
                    if (count_reg == CNT_BITS'(MAX_MARKERS))
                    begin
                        stat_next = 1'b1;
                        state_next = ST_OUT;
                    end
                    else
                    begin
                        wr_en = 1'b1;
                        count_next = count_reg + 1'b1;
                        state_next = ST_OUT;
                    end
                end
                else
                    state_next = ST_ICHK;
            end
            ST_ICHK:
            begin
                if (rd_src_reg < ms_reg)
                begin
                    idx_next = idx_reg + 1'b1;
                    state_next = ST_IRD;
                end
                else if (rd_src_reg == ms_reg)
                begin
                    if (mo_reg < rd_out_reg)
                    begin
                        wr_en = 1'b1;
                        wr_src = rd_src_reg;
                    end
                    state_next = ST_OUT;
                end
                else if (count_reg == CNT_BITS'(MAX_MARKERS))
                begin
                    stat_next = 1'b1;
                    state_next = ST_OUT;
                end
                else
                begin
                    // write new marker here, carry displaced entry upward
                    wr_en = 1'b1;
                    hold_src_next = rd_src_reg;
                    hold_out_next = rd_out_reg;
                    idx_next = idx_reg + 1'b1;
                    count_next = count_reg + 1'b1;
                    state_next = ST_SRD;
                end
            end
            ST_SRD:
            begin
                // count_reg already incremented; last slot is count-1
                if (idx_reg == count_reg - 1'b1)
                begin
                    wr_en = 1'b1;
                    wr_src = hold_src_reg;  wr_out = hold_out_reg;
                    state_next = ST_OUT;
                end
                else
                    state_next = ST_SWR;
            end
            ST_SWR:
            begin
                wr_en = 1'b1;
                wr_src = hold_src_reg;  wr_out = hold_out_reg;
                hold_src_next = rd_src_reg;  hold_out_next = rd_out_reg;
                idx_next = idx_reg + 1'b1;
                state_next = ST_SRD;
            end
            // query: output limit pass
            ST_LRD:
            begin
                if (lim_reg == '0 || q_reg == '0)
                    state_next = ST_OUT;
                else if (idx_reg == count_reg)
                begin
                    if (oe_reg <= 0)
                        oe_next = (proj_reg != '0) ? wide_t'({1'b0, proj_reg}) : lim_w;
                    idx_next = '0;
                    ps_next = '0;  po_next = '0;
                    state_next = ST_WRD;
                end
                else
                    state_next = ST_LCHK;
            end
            ST_LCHK:
            begin
                if (wide_t'(rd_src_reg) == lim_w && wide_t'(rd_out_reg) > oe_reg)
                    oe_next = wide_t'(rd_out_reg);
                idx_next = idx_reg + 1'b1;
                state_next = ST_LRD;
            end
            // query: segment walk
            ST_WRD:
            begin
                if (oe_reg <= 1 || idx_reg == count_reg)
                begin
                    s_next = lim_w;  o_next = oe_reg;
                    state_next = ST_MUL;
                end
                else
                    state_next = ST_WCHK;
            end
            ST_WCHK:
            begin
                idx_next = idx_reg + 1'b1;
                state_next = ST_WRD;
                clo = wide_t'(rd_out_reg);
                if (clo < 1)
                    clo = wide_t'(1);
                if (clo > oe_reg - wide_t'(1))
                    clo = oe_reg - wide_t'(1);
                if (!(wide_t'(rd_src_reg) <= ps_reg || wide_t'(rd_src_reg) >= lim_w)
                    && clo > po_reg)
                begin
                    if (q_reg <= wide_t'(rd_src_reg))
                    begin
                        s_next = wide_t'(rd_src_reg);  o_next = clo;
                        state_next = ST_MUL;
                    end
                    else
                    begin
                        ps_next = wide_t'(rd_src_reg);  po_next = clo;
                    end
                end
            end
            ST_MUL:
            begin
                num_next = {prod[PROD_BITS-2:0], 1'b0} + PROD_BITS'(span_w[FIELD_BITS-1:0]);
                den_next = PROD_BITS'({span_w[FIELD_BITS-1:0], 1'b0});
                rem_next = '0;
                dcnt_next = DCNT_BITS'(DIV_STEPS);
                state_next = ST_DIV;
            end
            // restoring divider, one quotient bit a cycle
            ST_DIV:
            begin
                if (trial >= {1'b0, den_reg})
                begin
                    rem_next = trial - {1'b0, den_reg};
                    num_next = {num_reg[PROD_BITS-2:0], 1'b1};
                end
                else
                begin
                    rem_next = trial;
                    num_next = {num_reg[PROD_BITS-2:0], 1'b0};
                end
                dcnt_next = dcnt_reg - 1'b1;
                if (dcnt_reg == DCNT_BITS'(1))
                    state_next = ST_DONE;
            end
            ST_DONE:
            begin
                res_next = po_reg[FRAME_BITS-1:0] + num_reg[FRAME_BITS-1:0];
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (out_ch.ready)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && in_ch.valid)
        begin
            ms_reg  <= in_ch.marker_source;
            mo_reg  <= in_ch.marker_output;
        end
        idx_reg <= idx_next;  q_reg <= q_next;  oe_reg <= oe_next;
        ps_reg <= ps_next;  po_reg <= po_next;  s_reg <= s_next;  o_reg <= o_next;
        hold_src_reg <= hold_src_next;  hold_out_reg <= hold_out_next;
        num_reg <= num_next;  den_reg <= den_next;  rem_reg <= rem_next;
        dcnt_reg <= dcnt_next;  res_reg <= res_next;  stat_reg <= stat_next;
    end
endmodule

// ===== bench/tb_warp_marker_piecewise_linear_map_core.sv =====
// Self-checking bench for the warp marker piecewise linear map core.
// Depends on wmpl_pkg and the channel interfaces in wmpl_if.sv.
`timescale 1ns / 1ps

module tb_warp_marker_piecewise_linear_map_core;
    import wmpl_pkg::*;

    typedef struct packed {
        frame_t mapped;
        logic   status;
    } answer_t;

    logic clk;
    logic rst_n;

    wmpl_in_if  in_ch ();
    wmpl_out_if out_ch ();
    wmpl_cfg_if cfg_ch ();

    warp_marker_piecewise_linear_map_core u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch.sink),
        .out_ch (out_ch.source),
        .cfg_ch (cfg_ch.sink)
    );

    // Local copy of the marker table and registers
    longint tbl_src[MAX_MARKERS];
    longint tbl_out[MAX_MARKERS];
    int     tbl_count;
    longint src_limit;
    longint proj_count;

    answer_t answers_due[$];
    int      mismatches;
    int      idle_cycles;
    bit      timed_out;
    int      send_idle_pct;
    int      recv_idle_pct;
    bit      hold_off;

    // Clock: period 8 ns
    initial clk = 1'b0;
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic longint round_segment(longint q, longint ps, longint po,
                                             longint s, longint o);
        longint span;
        longint dout;
        longint num;
        span = (s - ps > 1) ? s - ps : 1;
        dout = (o > po) ? o - po : 0;
        num  = (q - ps) * dout;
        return po + (2 * num + span) / (2 * span);
    endfunction

    function automatic frame_t map_frame(longint qraw);
        longint q;
        longint oe;
        longint ps;
        longint po;
        longint s;
        longint o;
        oe = 0;
        ps = 0;
        po = 0;
        if (src_limit == 0)
            return '0;
        q = (qraw < 0) ? 0 : ((qraw > src_limit) ? src_limit : qraw);
        if (q == 0)
            return '0;
        for (int i = 0; i < tbl_count; i++)
            if (tbl_src[i] == src_limit && tbl_out[i] > oe)
                oe = tbl_out[i];
        if (oe <= 0)
            oe = (proj_count > 0) ? proj_count : src_limit;
        if (oe > 1)
        begin
            for (int i = 0; i < tbl_count; i++)
            begin
                s = tbl_src[i];
                o = tbl_out[i];
                if (s <= ps || s >= src_limit)
                    continue;
                if (o < 1)
                    o = 1;
                if (o > oe - 1)
                    o = oe - 1;
                if (o <= po)
                    continue;
                if (q <= s)
                    return frame_t'(round_segment(q, ps, po, s, o));
                ps = s;
                po = o;
            end
        end
        return frame_t'(round_segment(q, ps, po, src_limit, oe));
    endfunction

    function automatic logic place_marker(longint s, longint o);
        int pos;
        pos = 0;
        while (pos < tbl_count && tbl_src[pos] < s)
            pos++;
        if (pos < tbl_count && tbl_src[pos] == s)
        begin
            if (o < tbl_out[pos])
                tbl_out[pos] = o;
            return 1'b0;
        end
        if (tbl_count >= MAX_MARKERS)
            return 1'b1;
        for (int i = tbl_count; i > pos; i--)
        begin
            tbl_src[i] = tbl_src[i-1];
            tbl_out[i] = tbl_out[i-1];
        end
        tbl_src[pos] = s;
        tbl_out[pos] = o;
        tbl_count++;
        return 1'b0;
    endfunction

    function automatic answer_t apply_command(logic [1:0] cmd, field_t ms, field_t mo,
                                              field_t qs);
        answer_t a;
        a = '0;
        if (cmd == CMD_CLEAR)
            tbl_count = 0;
        else if (cmd == CMD_INSERT)
            a.status = place_marker(longint'(ms), longint'(mo));
        else if (cmd == CMD_QUERY)
            a.mapped = map_frame(longint'(qs));
        return a;
    endfunction

    // Send one item, with random idle before it
    task automatic send_item(logic [1:0] cmd, field_t ms, field_t mo, field_t qs);
        while ($urandom_range(99) < send_idle_pct)
            @(posedge clk);
        in_ch.valid         <= 1'b1;
        in_ch.command       <= cmd;
        in_ch.marker_source <= ms;
        in_ch.marker_output <= mo;
        in_ch.query_source  <= qs;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        answers_due.insert(answers_due.size(), apply_command(cmd, ms, mo, qs));
        in_ch.valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic write_reg(logic [0:0] idx, frame_t val);
        while (answers_due.size() != 0)
            @(posedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= val;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        cfg_ch.valid <= 1'b0;
        if (idx == CFG_SRC_LIMIT)
            src_limit = longint'(val);
        else
            proj_count = longint'(val);
        @(posedge clk);
    endtask

    task automatic send_insert(longint s, longint o);
        send_item(CMD_INSERT, field_t'(s), field_t'(o), field_t'($urandom));
    endtask

    task automatic send_query(longint q);
        send_item(CMD_QUERY, field_t'($urandom), field_t'($urandom), field_t'(q));
    endtask

    function automatic longint rand_field();
        return longint'(field_t'($urandom));
    endfunction

    // Extremes of the fields, every command, clamps and duplicates
    task automatic test_directed();
        send_query(100);
        write_reg(CFG_SRC_LIMIT, 24'd1000);
        write_reg(CFG_PROJ_COUNT, 24'd0);
        send_query(-16777216);
        send_query(0);
        send_query(16777215);
        send_query(500);
        send_insert(250, 100);
        send_insert(250, 300);
        send_insert(250, 80);
        send_insert(500, -16777216);
        send_insert(600, 16777215);
        send_insert(-16777216, 5);
        send_insert(1000, 2000);
        send_insert(16777215, 7);
        send_query(249);
        send_query(700);
        send_query(999);
        send_item(CMD_NONE, field_t'(-1), field_t'(-1), field_t'(-1));
        send_item(CMD_CLEAR, '0, '0, '0);
        send_query(333);
        write_reg(CFG_PROJ_COUNT, 24'd1);
        send_insert(10, 5);
        send_query(333);
        write_reg(CFG_SRC_LIMIT, 24'hFFFFFF);
        write_reg(CFG_PROJ_COUNT, 24'hFFFFFF);
        send_query(16777215);
        send_query(8388607);
    endtask

    // Fill past the table depth to hit dropped inserts
    task automatic test_full_table();
        send_item(CMD_CLEAR, '0, '0, '0);
        for (int i = 0; i < MAX_MARKERS + 4; i++)
            send_insert(longint'($urandom_range(50000)), rand_field());
        send_insert(tbl_src[3], -5);
        for (int i = 0; i < 6; i++)
            send_query(longint'($urandom_range(60000)));
    endtask

    // Receiver stalls for a long stretch while items keep coming
    task automatic test_backpressure();
        hold_off = 1'b1;
        fork
            begin
                repeat (600) @(posedge clk);
                hold_off = 1'b0;
            end
            for (int i = 0; i < 8; i++)
                send_query(longint'($urandom_range(70000)));
        join
    endtask

    // Random phases: well-formed tables and queries, plus noise
    task automatic test_random(int n_items);
        int kind;
        for (int k = 0; k < n_items; k++)
        begin
            kind = $urandom_range(99);
            if (kind < 3)
                send_item(CMD_CLEAR, field_t'($urandom), field_t'($urandom),
                          field_t'($urandom));
            else if (kind < 5)
                send_item(CMD_NONE, field_t'($urandom), field_t'($urandom),
                          field_t'($urandom));
            else if (kind < 35)
            begin
                if ($urandom_range(9) == 0)
                    send_insert(rand_field(), rand_field());
                else if ($urandom_range(9) == 0)
                    send_insert(src_limit, longint'($urandom_range(200000)));
                else
                    send_insert(longint'($urandom_range(32'(src_limit + 5))),
                                longint'($urandom_range(32'(src_limit + 5))) - 3);
            end
            else if ($urandom_range(9) == 0)
                send_query(rand_field());
            else
                send_query(longint'($urandom_range(32'(src_limit + 3))));
        end
    endtask

    // Result checker
    always @(posedge clk)
    begin
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            if (answers_due.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result item: mapped %0d status %0d",
                             out_ch.mapped_frame, out_ch.status);
            end
            else
            begin
                answer_t want;
                want = answers_due.pop_front();
                if (out_ch.mapped_frame !== want.mapped || out_ch.status !== want.status)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: mapped exp %0d got %0d, status exp %0d got %0d",
                                 want.mapped, out_ch.mapped_frame, want.status,
                                 out_ch.status);
                end
            end
        end
    end

    // Receiver ready
    always @(posedge clk)
    begin
        if (!rst_n)
            out_ch.ready <= 1'b0;
        else
            out_ch.ready <= !hold_off && ($urandom_range(99) >= recv_idle_pct);
    end

    // Watchdog on cycles with no handshake
    always @(posedge clk)
    begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
            (cfg_ch.valid && cfg_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 20000 && !timed_out)
        begin
            timed_out = 1'b1;
            $display("tb_warp_marker_piecewise_linear_map_core failed");
            $finish;
        end
    end

    initial
    begin
        rst_n         = 1'b0;
        in_ch.valid   = 1'b0;
        in_ch.command = CMD_CLEAR;
        in_ch.marker_source = '0;
        in_ch.marker_output = '0;
        in_ch.query_source  = '0;
        cfg_ch.valid  = 1'b0;
        cfg_ch.index  = CFG_SRC_LIMIT;
        cfg_ch.data   = '0;
        tbl_count     = 0;
        src_limit     = 0;
        proj_count    = 0;
        mismatches    = 0;
        idle_cycles   = 0;
        timed_out     = 1'b0;
        hold_off      = 1'b0;
        send_idle_pct = 7;
        recv_idle_pct = 87;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_full_table();
        write_reg(CFG_SRC_LIMIT, 24'd60000);
        write_reg(CFG_PROJ_COUNT, 24'd90000);
        test_backpressure();
        test_random(330);

        send_idle_pct = 87;
        recv_idle_pct = 7;
        write_reg(CFG_SRC_LIMIT, 24'd0);
        test_random(40);
        write_reg(CFG_SRC_LIMIT, 24'd300);
        write_reg(CFG_PROJ_COUNT, 24'd0);
        test_random(330);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_reg(CFG_SRC_LIMIT, 24'hFFFFFF);
        write_reg(CFG_PROJ_COUNT, 24'd2);
        test_random(150);
        write_reg(CFG_PROJ_COUNT, 24'd12345);
        write_reg(CFG_SRC_LIMIT, 24'd5000);
        test_random(200);

        while (answers_due.size() != 0)
            @(posedge clk);
        repeat (400) @(posedge clk);
        if (mismatches == 0)
            $display("tb_warp_marker_piecewise_linear_map_core passed");
        else
            $display("tb_warp_marker_piecewise_linear_map_core failed");
        $finish;
    end
endmodule

// ===== filelist.f =====
rtl/core/wmpl_pkg.sv
rtl/core/wmpl_if.sv
rtl/core/warp_marker_piecewise_linear_map_core.sv
bench/tb_warp_marker_piecewise_linear_map_core.sv
